@@ rtl/core/sfr_pkg.sv @@
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int DEF_MAX_PATTERN = 8;
    localparam int REPL_MAX        = 8;
    localparam int REPL_IDX_W      = $clog2(REPL_MAX);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REPL,
        ST_FLUSH,
        ST_MARK
    } sfr_state_t;

    // window control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
    } win_ctl_t;

endpackage

@@ rtl/core/sfr_cell.sv @@
// one window cell: holds a pending byte and compares it with its pattern byte
module sfr_cell (
    input  logic                       aclk,
    input  logic                       load_en,
    input  logic                       shift_en,
    input  logic [sfr_pkg::BYTE_W-1:0] load_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] shift_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] pat_byte,
    input  logic                       used,
    output logic [sfr_pkg::BYTE_W-1:0] cell_byte,
    output logic                       cell_match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // load from the input or take the neighbor's byte
    always_comb begin
        byte_next = byte_reg;
        if (load_en) begin
            byte_next = load_byte;
        end else if (shift_en) begin
            byte_next = shift_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign cell_byte  = byte_reg;
    // cells past the pattern length always agree
    assign cell_match = !used || (byte_reg == pat_byte);

endmodule

@@ rtl/core/sfr_window.sv @@
// row of window cells, oldest byte at cell 0, shifting toward cell 0
module sfr_window #(
    parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
    parameter int CNT_W       = $clog2(MAX_PATTERN + 1),
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                       aclk,
    input  sfr_pkg::win_ctl_t          ctl,
    input  logic [IDX_W-1:0]           load_idx,
    input  logic [sfr_pkg::BYTE_W-1:0] load_byte,
    input  logic [sfr_pkg::CFG_W-1:0]  pattern,
    input  logic [CNT_W-1:0]           plen,
    output logic [sfr_pkg::BYTE_W-1:0] head_byte,
    output logic                       match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0]      cell_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_match;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            logic [BYTE_W-1:0] shift_byte;

            // last cell shifts in filler, never read
            if (k == MAX_PATTERN - 1) begin : g_end
                assign shift_byte = '0;
            end else begin : g_mid
                assign shift_byte = cell_bytes[k+1];
            end

            sfr_cell u_cell (
                .aclk       (aclk),
                .load_en    (ctl.load && (load_idx == IDX_W'(k))),
                .shift_en   (ctl.shift),
                .load_byte  (load_byte),
                .shift_byte (shift_byte),
                .pat_byte   (pattern[k*BYTE_W +: BYTE_W]),
                .used       (CNT_W'(k) < plen),
                .cell_byte  (cell_bytes[k]),
                .cell_match (cell_match[k])
            );
        end
    endgenerate

    assign head_byte = cell_bytes[0];
    assign match     = &cell_match;

endmodule

@@ rtl/core/stream_find_and_replace.sv @@
// stream find-and-replace top level: config registers, sequencer, output register
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid s_ready s_in_byte s_in_last     | in
//  result   | m_valid m_ready m_out_byte m_out_valid  | out
//           | m_out_last                              |
//  config   | cfg_wr_en cfg_index cfg_wdata           | in
//
// A byte loads into the cell row at its transfer and is evaluated the next cycle;
// a mismatch or pass-through emits there, a match emits nothing. Each replacement
// byte, further flushed byte or end marker then follows as a result of its own.
// The output register frees the sequencer: the next byte is accepted while a
// result still waits. A stalled m_ready holds the sequencer in place.
// Reset is synchronous, active low, and clears config, count and handshakes.
module stream_find_and_replace #(
    parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]    s_in_byte,
    input  logic                          s_in_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                          m_out_valid,
    output logic                          m_out_last,
    input  logic                          cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]     cfg_wdata
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CFG_W-1:0]      pattern_bytes_reg;
    logic [LEN_W-1:0]      pattern_len_reg;
    logic [CFG_W-1:0]      replace_bytes_reg;
    logic [LEN_W-1:0]      replace_len_reg;

    sfr_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  last_item_reg, last_item_next;
    logic [REPL_IDX_W-1:0] rep_idx_reg, rep_idx_next;

    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]     m_byte_reg;
    logic                  m_bvalid_reg;
    logic                  m_last_reg;

    logic                  emit;
    logic [BYTE_W-1:0]     emit_byte;
    logic                  emit_bvalid;
    logic                  emit_last;

    win_ctl_t              win_ctl;
    logic [IDX_W-1:0]      load_idx;
    logic [BYTE_W-1:0]     head_byte;
    logic                  win_match;

    logic [LEN_W-1:0]      plen_wide;
    logic [CNT_W-1:0]      plen;
    logic [LEN_W-1:0]      rlen;
    logic [CNT_W-1:0]      start_cnt;
    logic                  out_free;
    logic                  in_xfer;

    // effective lengths, clamped to the hardware limits
    assign plen_wide = (pattern_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                               : pattern_len_reg;
    assign plen      = CNT_W'(plen_wide);
    assign rlen      = (replace_len_reg > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX)
                                                            : replace_len_reg;

    // a full window starts over at cell 0
    assign start_cnt = (count_reg >= plen) ? '0 : count_reg;
    assign load_idx  = start_cnt[IDX_W-1:0];

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg <= '0;
            pattern_len_reg   <= '0;
            replace_bytes_reg <= '0;
            replace_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_BYTES: pattern_bytes_reg <= cfg_wdata;
                CFG_PATTERN_LEN:   pattern_len_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_BYTES: replace_bytes_reg <= cfg_wdata;
                CFG_REPLACE_LEN:   replace_len_reg   <= cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_item_reg <= 1'b0;
            rep_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_item_reg <= last_item_next;
            rep_idx_reg   <= rep_idx_next;
        end
    end

    // next state, window control and result generation
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_item_next = last_item_reg;
        rep_idx_next   = rep_idx_reg;
        win_ctl        = '{load: 1'b0, shift: 1'b0};
        emit           = 1'b0;
        emit_byte      = head_byte;
        emit_bvalid    = 1'b1;
        emit_last      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en && (cfg_index == CFG_PATTERN_LEN)) begin
                    count_next = '0;
                end
                if (in_xfer) begin
                    win_ctl.load   = 1'b1;
                    count_next     = start_cnt + CNT_W'(1);
                    last_item_next = s_in_last;
                    state_next     = ST_EVAL;
                end
            end

            ST_EVAL: begin
                if (out_free) begin
                    if (plen == '0) begin
                        // pass-through
                        emit       = 1'b1;
                        emit_last  = last_item_reg;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else if (count_reg == plen && win_match) begin
                        count_next   = '0;
                        rep_idx_next = '0;
                        if (rlen != '0) begin
                            state_next = ST_REPL;
                        end else if (last_item_reg) begin
                            state_next = ST_MARK;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else if (count_reg == plen) begin
                        // mismatch: release the oldest byte
                        emit          = 1'b1;
                        emit_last     = last_item_reg && (count_reg == CNT_W'(1));
                        win_ctl.shift = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        if (last_item_reg && (count_reg != CNT_W'(1))) begin
                            state_next = ST_FLUSH;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else if (last_item_reg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_REPL: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = replace_bytes_reg[rep_idx_reg*BYTE_W +: BYTE_W];
                    if ({1'b0, rep_idx_reg} + LEN_W'(1) == rlen) begin
                        emit_last  = last_item_reg;
                        state_next = ST_IDLE;
                    end else begin
                        rep_idx_next = rep_idx_reg + REPL_IDX_W'(1);
                    end
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_last     = (count_reg == CNT_W'(1));
                    win_ctl.shift = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MARK: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_byte   = '0;
                    emit_bvalid = 1'b0;
                    emit_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pending byte window
    sfr_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_window (
        .aclk      (aclk),
        .ctl       (win_ctl),
        .load_idx  (load_idx),
        .load_byte (s_in_byte),
        .pattern   (pattern_bytes_reg),
        .plen      (plen),
        .head_byte (head_byte),
        .match     (win_match)
    );

    // output register
    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg   <= emit_byte;
            m_bvalid_reg <= emit_bvalid;
            m_last_reg   <= emit_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_out_valid = m_bvalid_reg;
    assign m_out_last  = m_last_reg;

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PATTERN))
        else $error("window count above pattern limit");

    a_xfer_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_EVAL))
        else $error("accepted byte not evaluated next cycle");

    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> (count_reg != '0))
        else $error("flush with empty window");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_valid) |-> m_out_last)
        else $error("empty marker without last flag");

    a_no_emit_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result produced while output register is held");

endmodule

@@ sim/stream_find_and_replace_test.sv @@
// self-checking testbench for the stream find-and-replace block
module stream_find_and_replace_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } text_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } text_item_t;

    // predicts the rewritten text stream and checks the block's results against it
    class replace_scoreboard;
        logic [CFG_W-1:0]  pat_bytes = '0;
        logic [LEN_W-1:0]  pat_len   = '0;
        logic [CFG_W-1:0]  rep_bytes = '0;
        logic [LEN_W-1:0]  rep_len   = '0;
        logic [BYTE_W-1:0] win [DEF_MAX_PATTERN] = '{default: '0};
        int                win_cnt   = 0;
        text_beat_t        expected_q[$];
        text_beat_t        step_q[$];
        int                errors    = 0;

        // pattern lengths above the window depth behave as the full window
        function int active_len();
            return (pat_len > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : int'(pat_len);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_PATTERN_BYTES: pat_bytes = value;
                CFG_PATTERN_LEN: begin
                    pat_len = value[LEN_W-1:0];
                    win_cnt = 0;
                end
                CFG_REPLACE_BYTES: rep_bytes = value;
                CFG_REPLACE_LEN:   rep_len = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_beat(logic [BYTE_W-1:0] data, logic valid);
            text_beat_t beat;
            beat.data  = data;
            beat.valid = valid;
            beat.last  = 1'b0;
            step_q.push_back(beat);
        endfunction

        // one accepted input byte: slide the window and queue what it releases
        function void note_input(logic [BYTE_W-1:0] data, logic last);
            int plen;
            int rlen;
            bit hit;
            plen = active_len();
            rlen = (rep_len > REPL_MAX) ? REPL_MAX : int'(rep_len);
            step_q.delete();
            if (plen == 0) begin
                win_cnt = 0;
                add_beat(data, 1'b1);
            end else begin
                if (win_cnt >= plen) win_cnt = 0;
                win[win_cnt] = data;
                win_cnt++;
                if (win_cnt == plen) begin
                    hit = 1'b1;
                    for (int k = 0; k < plen; k++)
                        if (win[k] != pat_bytes[BYTE_W*k +: BYTE_W]) hit = 1'b0;
                    if (hit) begin
                        for (int k = 0; k < rlen; k++)
                            add_beat(rep_bytes[BYTE_W*k +: BYTE_W], 1'b1);
                        win_cnt = 0;
                    end else begin
                        add_beat(win[0], 1'b1);
                        for (int k = 1; k < DEF_MAX_PATTERN; k++) win[k-1] = win[k];
                        win[DEF_MAX_PATTERN-1] = '0;
                        win_cnt--;
                    end
                end
            end
            // end of string: flush the window, or send an empty marker
            if (last) begin
                for (int k = 0; k < win_cnt; k++) add_beat(win[k], 1'b1);
                win_cnt = 0;
                if (step_q.size() == 0) add_beat('0, 1'b0);
                step_q[step_q.size()-1].last = 1'b1;
            end
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic valid, logic last);
            text_beat_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_byte %h out_valid %b out_last %b",
                       data, valid, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data) begin
                $error("out_byte mismatch: expected %h, actual %h", want.data, data);
                errors++;
            end
            if (valid !== want.valid) begin
                $error("out_valid mismatch: expected %b, actual %b", want.valid, valid);
                errors++;
            end
            if (last !== want.last) begin
                $error("out_last mismatch: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_PCT     = 34;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte;
    logic                 s_in_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_out_valid;
    logic                 m_out_last;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    replace_scoreboard sb;
    text_item_t        text_q[$];
    int                queued_items   = 0;
    int                accepted_items = 0;
    bit                calm           = 1'b0;
    int                cycle_count    = 0;

    stream_find_and_replace dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // input side: hold the byte until its transfer, then maybe idle
    initial begin
        text_item_t item;
        s_valid   <= 1'b0;
        s_in_byte <= '0;
        s_in_last <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                sb.note_input(s_in_byte, s_in_last);
                accepted_items++;
            end
            if (!(s_valid && !s_ready)) begin
                if (text_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    item = text_q.pop_front();
                    s_valid   <= 1'b1;
                    s_in_byte <= item.data;
                    s_in_last <= item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: check each transfer, stall at random
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_out_byte, m_out_valid, m_out_last);
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_byte(logic [BYTE_W-1:0] data, logic last);
        text_item_t item;
        item.data = data;
        item.last = last;
        text_q.push_back(item);
        queued_items++;
    endtask

    // wait until every byte is taken and every result is back, then let the block settle
    task automatic settle();
        do @(posedge aclk);
        while (accepted_items != queued_items || sb.expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // text built mostly from whole and partial copies of the current pattern
    task automatic queue_string(int len, bit close);
        logic [BYTE_W-1:0] text[$];
        int plen;
        int r;
        int cut;
        plen = sb.active_len();
        while (text.size() < len) begin
            r = $urandom_range(0, 9);
            if (plen > 0 && r <= 3) begin
                for (int k = 0; k < plen; k++) text.push_back(sb.pat_bytes[BYTE_W*k +: BYTE_W]);
            end else if (plen > 1 && r <= 5) begin
                cut = $urandom_range(1, plen - 1);
                for (int k = 0; k < cut; k++) text.push_back(sb.pat_bytes[BYTE_W*k +: BYTE_W]);
            end else if (plen > 0 && r <= 7) begin
                cut = $urandom_range(0, plen - 1);
                text.push_back(sb.pat_bytes[BYTE_W*cut +: BYTE_W]);
            end else begin
                text.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
        foreach (text[i]) queue_byte(text[i], close && (i == text.size() - 1));
    endtask

    // length value with random upper bits, sometimes zero or oversized
    function automatic logic [CFG_W-1:0] pick_len();
        logic [CFG_W-1:0] value;
        int r;
        value = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r == 0) value[LEN_W-1:0] = '0;
        else if (r == 1) value[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
        else value[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
        return value;
    endfunction

    task automatic random_setup();
        logic [CFG_W-1:0] pat;
        logic [CFG_W-1:0] rep;
        int mode;
        pat  = {$urandom, $urandom};
        rep  = {$urandom, $urandom};
        mode = $urandom_range(0, 3);
        // two-letter alphabet gives self-overlapping patterns; zero bytes are ordinary
        for (int k = 0; k < DEF_MAX_PATTERN; k++) begin
            if (mode == 0) pat[BYTE_W*k +: BYTE_W] = 8'h61 + 8'($urandom_range(0, 1));
            else if (mode == 1 && $urandom_range(0, 2) == 0) pat[BYTE_W*k +: BYTE_W] = '0;
        end
        cfg_write(CFG_PATTERN_BYTES, pat);
        cfg_write(CFG_REPLACE_BYTES, rep);
        // sometimes keep the length so a pending window carries over
        if ($urandom_range(0, 3) != 0) cfg_write(CFG_PATTERN_LEN, pick_len());
        cfg_write(CFG_REPLACE_LEN, pick_len());
    endtask

    // reset, directed cases, random phases, final verdict
    initial begin
        int phase_start;
        int phase_end;
        int random_count;
        int phase;
        sb           = new();
        random_count = 0;
        phase        = 0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // pass-through after reset, extreme byte values
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h55, 1'b1);
        settle();

        // "xy" becomes "Q": a match, a miss, a partial window flushed at the end
        cfg_write(CFG_PATTERN_BYTES, 64'h7978);
        cfg_write(CFG_PATTERN_LEN, 64'd2);
        cfg_write(CFG_REPLACE_BYTES, 64'h51);
        cfg_write(CFG_REPLACE_LEN, 64'd1);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h79, 1'b0);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h7A, 1'b0);
        queue_byte(8'h71, 1'b1);
        queue_byte(8'h78, 1'b1);
        settle();

        // empty replacement: a match at the end leaves only the marker
        cfg_write(CFG_REPLACE_LEN, 64'd0);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h79, 1'b1);
        settle();

        // oversized lengths act as eight, all-ones pattern
        cfg_write(CFG_PATTERN_BYTES, '1);
        cfg_write(CFG_PATTERN_LEN, 64'd15);
        cfg_write(CFG_REPLACE_BYTES, 64'h0123_4567_89AB_CDEF);
        cfg_write(CFG_REPLACE_LEN, 64'd15);
        for (int k = 0; k < 8; k++) queue_byte(8'hFF, k == 7);
        settle();

        // zero bytes in the pattern; a length write drops the pending window
        cfg_write(CFG_PATTERN_BYTES, 64'd0);
        cfg_write(CFG_PATTERN_LEN, 64'd3);
        cfg_write(CFG_REPLACE_LEN, 64'd2);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        settle();
        cfg_write(CFG_PATTERN_LEN, 64'd3);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        settle();

        // random phases, one of them without any idling
        while (random_count < RANDOM_ITEMS) begin
            calm = (phase == 2);
            random_setup();
            phase_start = queued_items;
            phase_end   = phase_start + $urandom_range(30, 50);
            while (queued_items < phase_end)
                queue_string($urandom_range(1, 24), $urandom_range(0, 7) != 0);
            random_count += queued_items - phase_start;
            settle();
            phase++;
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
